/* src/tdpt_pkg.sv */
// Package with the shared width constant, sequencer states and control structs.
package tdpt_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_status_t;

	typedef struct packed {
		logic valid;
		logic flag;
	} result_t;

endpackage

/* src/tdpt_rem.sv */
// Shared remainder unit: restoring division, one quotient bit per cycle.
module tdpt_rem (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tdpt_pkg::DATA_WIDTH-1:0]   dividend,
	input  logic [tdpt_pkg::DATA_WIDTH-1:0]   divisor,
	output tdpt_pkg::rem_status_t             status
);
	import tdpt_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH-1:0] shift_q;
	logic [DATA_WIDTH-1:0] div_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;
	logic                  fits;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {rem_q, shift_q[DATA_WIDTH-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			div_q   <= divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[DATA_WIDTH-2:0], 1'b0};
			rem_q   <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
		end
	end

	assign status.done = done_q;
	assign status.zero = (rem_q == '0);

endmodule

/* src/tdpt_seq.sv */
// Sequencer that steps the trial divisor and drives the shared remainder unit.
module tdpt_seq (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [tdpt_pkg::DATA_WIDTH-1:0] candidate,
	output tdpt_pkg::result_t                      result,
	input  logic                                   result_ack,
	output logic                                   rem_start,
	output logic [tdpt_pkg::DATA_WIDTH-1:0]        rem_dividend,
	output logic [tdpt_pkg::DATA_WIDTH-1:0]        rem_divisor,
	input  tdpt_pkg::rem_status_t                  rem_status
);
	import tdpt_pkg::*;

	state_t                state_q, state_d;
	logic [DATA_WIDTH-1:0] n_q;
	logic [DATA_WIDTH-1:0] d_q;
	logic [DATA_WIDTH:0]   sq_q;
	logic                  flag_q;
	logic                  accept;
	logic                  trivial;
	logic                  sq_over;

	assign accept  = in_valid && (state_q == ST_IDLE);
	// Negative values, zero and one are never prime.
	assign trivial = candidate[DATA_WIDTH-1] ||
		(candidate[DATA_WIDTH-1:1] == '0);
	// The search ends once the divisor squared passes the value.
	assign sq_over = sq_q > {1'b0, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		rem_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = trivial ? ST_DONE : ST_TEST;
				end
			end
			ST_TEST: begin
				if (sq_over) begin
					state_d = ST_DONE;
				end else begin
					rem_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (rem_status.done) begin
					state_d = rem_status.zero ? ST_DONE : ST_TEST;
				end
			end
			ST_DONE: begin
				if (result_ack) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q    <= candidate;
			d_q    <= DATA_WIDTH'(2);
			sq_q   <= (DATA_WIDTH + 1)'(4);
			flag_q <= 1'b0;
		end else if (state_q == ST_TEST && sq_over) begin
			flag_q <= 1'b1;
		end else if (state_q == ST_DIV && rem_status.done && !rem_status.zero) begin
			// (d+1)^2 = d^2 + 2d + 1
			sq_q <= sq_q + {d_q, 1'b1};
			d_q  <= d_q + 1'b1;
		end
	end

	assign rem_dividend = n_q;
	assign rem_divisor  = d_q;
	assign result.valid = (state_q == ST_DONE);
	assign result.flag  = flag_q;

endmodule

/* src/trial_division_prime_test_top.sv */
// Top level: trial-division prime test with an output word register.
// A negative value, zero or one goes straight to the result; any other value is divided by
// each trial divisor in turn in the bit-serial remainder unit, until one divides it or the
// square of the divisor passes the value.
// One word is in work at a time; the next is taken while a result waits.
// Reset (arst_n, asynchronous) returns the block to idle with no result.
module trial_division_prime_test_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [tdpt_pkg::DATA_WIDTH-1:0] candidate,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   prime_flag
);
	import tdpt_pkg::*;

	result_t               result;
	logic                  result_ack;
	logic                  rem_start;
	logic [DATA_WIDTH-1:0] rem_dividend;
	logic [DATA_WIDTH-1:0] rem_divisor;
	rem_status_t           rem_status;
	logic                  out_valid_q;
	logic                  flag_q;

	assign result_ack = result.valid && (!out_valid_q || out_ready);

	tdpt_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.candidate    (candidate),
		.result       (result),
		.result_ack   (result_ack),
		.rem_start    (rem_start),
		.rem_dividend (rem_dividend),
		.rem_divisor  (rem_divisor),
		.rem_status   (rem_status)
	);

	tdpt_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dividend),
		.divisor  (rem_divisor),
		.status   (rem_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_ack) begin
			flag_q <= result.flag;
		end
	end

	assign out_valid  = out_valid_q;
	assign prime_flag = flag_q;

endmodule

/* src/tdpt_checker.sv */
// Port-level checker for the prime test top level, with its bind.
module tdpt_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic signed [tdpt_pkg::DATA_WIDTH-1:0] candidate,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic                                   prime_flag
);

	// An input word that is not taken holds its value.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(candidate))
		else $error("input word changed while waiting");

	// A result word that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime_flag))
		else $error("result word changed while stalled");

	// The block works on one word at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again before the result was produced");

	// A new result appears only at the end of a busy period.
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a word in work");

	// Returning to idle always leaves a result in the output register.
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("block went idle without a result");

endmodule

bind trial_division_prime_test_top tdpt_checker u_tdpt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.candidate  (candidate),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.prime_flag (prime_flag)
);

/* sim/trial_division_prime_test_top_test.sv */
// Testbench for the trial-division prime test: random and directed words, self-checking.
module trial_division_prime_test_top_test;

	import tdpt_pkg::*;

	typedef logic signed [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		word_t word;
		logic  flag;
	} verdict_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	word_t candidate;
	logic  out_valid;
	logic  out_ready;
	logic  prime_flag;

	word_t    words_waiting[$];
	verdict_t verdicts_due[$];
	verdict_t pending_verdict;
	verdict_t oldest_verdict;

	int   send_gap;
	int   recv_gap;
	bit   calm_send;
	bit   calm_recv;
	logic hold_results;
	int   blocked_run;
	int   longest_block;
	int   words_sent;
	int   words_checked;
	int   primes_seen;
	int   mismatches;
	int   spare_cost;

	trial_division_prime_test_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.candidate (candidate),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.prime_flag(prime_flag)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Trial division up to the square root; cost returns how many divisors were tried.
	function automatic logic prime_by_division(input word_t value, output int cost);
		longint unsigned n;
		longint unsigned d;
		logic            found;
		cost = 0;
		if (value < 2)
			return 1'b0;
		n = longint'(value);
		d = 2;
		found = 1'b0;
		while (!found && d <= n / d) begin
			if (n % d == 0)
				found = 1'b1;
			d++;
		end
		cost = int'(d - 2);
		return !found;
	endfunction

	// Sender: one word offered at a time, with a random gap drawn before each next word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			candidate <= '0;
			send_gap  <= 0;
		end else begin
			if (in_valid && !in_ready) begin
				blocked_run = blocked_run + 1;
				if (blocked_run > longest_block)
					longest_block = blocked_run;
			end else
				blocked_run = 0;
			if (!in_valid || in_ready) begin
				if (in_valid) begin
					pending_verdict.word = candidate;
					pending_verdict.flag = prime_by_division(candidate, spare_cost);
					verdicts_due.push_back(pending_verdict);
					words_sent++;
				end
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (words_waiting.size() != 0) begin
					in_valid  <= 1'b1;
					candidate <= words_waiting.pop_front();
					send_gap  <= calm_send ? 0 : $urandom_range(0, 4);
					if ($urandom_range(0, 11) == 0)
						calm_send = !calm_send;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Receiver: checks every result word against the oldest outstanding verdict.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: prime_flag=%b", prime_flag);
				end else begin
					oldest_verdict = verdicts_due.pop_front();
					words_checked++;
					if (oldest_verdict.flag)
						primes_seen++;
					if (prime_flag !== oldest_verdict.flag) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: candidate=%0d prime_flag expected %b got %b",
								oldest_verdict.word, oldest_verdict.flag, prime_flag);
					end
				end
				recv_gap = calm_recv ? 0 : $urandom_range(0, 4);
				if ($urandom_range(0, 11) == 0)
					calm_recv = !calm_recv;
			end else if (recv_gap != 0)
				recv_gap = recv_gap - 1;
			out_ready <= (recv_gap == 0) && !hold_results;
		end
	end

	// Results are held back for a long stretch after reset so that the block fills up.
	initial begin
		hold_results = 1'b1;
		wait (arst_n === 1'b1);
		repeat (400) @(posedge clk);
		hold_results <= 1'b0;
	end

	initial begin
		#400_000_000;
		$display("timeout with %0d words still outstanding", verdicts_due.size());
		$display("tb: failure");
		$finish;
	end

	initial begin
		word_t pick;
		int    cost;
		int    kind;
		int    a;
		int    b;
		arst_n        = 1'b0;
		calm_send     = 1'b0;
		calm_recv     = 1'b0;
		blocked_run   = 0;
		longest_block = 0;
		words_sent    = 0;
		words_checked = 0;
		primes_seen   = 0;
		mismatches    = 0;

		// Cheap words first so that they pile up while results are held back.
		words_waiting.push_back(32'h8000_0000);
		words_waiting.push_back(-1);
		words_waiting.push_back(-7);
		words_waiting.push_back(0);
		words_waiting.push_back(1);
		words_waiting.push_back(2);
		words_waiting.push_back(3);
		words_waiting.push_back(4);
		words_waiting.push_back(5);
		words_waiting.push_back(9);
		words_waiting.push_back(25);
		words_waiting.push_back(49);
		words_waiting.push_back(97);
		words_waiting.push_back(10403);
		words_waiting.push_back(65536);
		words_waiting.push_back(65521);
		words_waiting.push_back(65537);
		words_waiting.push_back(1018081);
		words_waiting.push_back(1000003);
		words_waiting.push_back(32'h5555_5555);
		words_waiting.push_back(32'h2AAA_AAAA);
		words_waiting.push_back(32'h7FFF_FFFE);
		// The largest positive word is prime and takes the full divisor sweep.
		words_waiting.push_back(32'h7FFF_FFFF);

		// Large words are redrawn until they stop within a modest number of divisors.
		for (int i = 0; i < 80; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 35)
				pick = $urandom_range(0, 1200);
			else if (kind < 50)
				pick = $urandom() | 32'h8000_0000;
			else if (kind < 75) begin
				a = $urandom_range(2, 1200);
				b = $urandom_range(2, 1200);
				pick = a * b;
			end else begin
				do begin
					if (kind < 88)
						pick = $urandom_range(0, 3000000);
					else
						pick = $urandom() & 32'h7FFF_FFFF;
					void'(prime_by_division(pick, cost));
				end while (cost > 1500);
			end
			words_waiting.push_back(pick);
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (words_waiting.size() != 0 || in_valid)
			@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("summary: %0d words sent, %0d results checked, %0d of them prime",
			words_sent, words_checked, primes_seen);
		$display("summary: longest input stall %0d cycles, %0d mismatches",
			longest_block, mismatches);
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
